>>> hdl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helpers for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int MAX_UNITS  = 3;
    localparam int HOLD_DEPTH = 3;
    localparam int SCAN_DEPTH = HOLD_DEPTH + 1;

    localparam logic [7:0]  ASCII_MASK  = 8'h80;
    localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE  = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK  = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE  = 8'hF0;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_CODE   = 8'h80;
    localparam logic [7:0]  PAYLOAD_MASK = 8'h3F;
    localparam logic [7:0]  LEAD2_BITS  = 8'h1F;
    localparam logic [7:0]  LEAD3_BITS  = 8'h0F;
    localparam logic [7:0]  LEAD4_BITS  = 8'h07;

    localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [15:0] HIGH_SURR   = 16'hD800;
    localparam logic [15:0] LOW_SURR    = 16'hDC00;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        string_done;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_UNITS-1:0]      units;
    } parse_t;

    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & ASCII_MASK) == 8'h00) begin
            len = 3'd1;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            len = 3'd2;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            len = 3'd3;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

>>> hdl/u8u16_decoder.sv
// ----------------------------------------------------------------------------
// u8u16_decoder
// Holds the bytes of an unfinished sequence and, for each new byte, scans the
// held bytes plus the new one into up to three UTF-16 code units.
// ----------------------------------------------------------------------------
module u8u16_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output u8u16_pkg::parse_t   parse
);

    localparam int HD = u8u16_pkg::HOLD_DEPTH;
    localparam int SD = u8u16_pkg::SCAN_DEPTH;
    localparam int MU = u8u16_pkg::MAX_UNITS;

    logic [1:0] held_cnt_reg;
    logic [1:0] held_cnt_next;
    logic [7:0] held_bytes_reg  [HD];
    logic [7:0] held_bytes_next [HD];

    always_comb begin
        logic [7:0]  scan [SD];
        logic [2:0]  total;
        logic [2:0]  pos;
        logic [2:0]  len;
        logic [2:0]  idx;
        logic [2:0]  rest;
        logic        stop;
        logic        ok;
        logic [7:0]  lead;
        logic [7:0]  cont;
        logic [20:0] cp;
        logic [20:0] cp_off;
        logic [1:0]  n;

        for (int j = 0; j < HD; j++) begin
            scan[j] = (2'(j) < held_cnt_reg) ? held_bytes_reg[j] : in_byte;
        end
        scan[SD-1] = in_byte;
        total  = {1'b0, held_cnt_reg} + 3'd1;
        pos    = 3'd0;
        stop   = 1'b0;
        n      = 2'd0;
        cp     = '0;
        cp_off = '0;
        parse  = '0;
        lead   = '0;
        len    = '0;
        rest   = '0;
        ok     = 1'b0;
        cont   = '0;
        idx    = '0;

        for (int it = 0; it < SD; it++) begin
            if (!stop && pos < total) begin
                lead = scan[pos[1:0]];
                len  = u8u16_pkg::seq_length(lead);
                rest = total - pos;
                if (len == 3'd0) begin
                    pos = pos + 3'd1;
                end else if (rest < len) begin
                    stop = 1'b1;
                end else begin
                    ok = 1'b1;
                    case (len)
                        3'd1:    cp = 21'(lead);
                        3'd2:    cp = 21'(lead & u8u16_pkg::LEAD2_BITS);
                        3'd3:    cp = 21'(lead & u8u16_pkg::LEAD3_BITS);
                        default: cp = 21'(lead & u8u16_pkg::LEAD4_BITS);
                    endcase
                    for (int k = 1; k < SD; k++) begin
                        idx  = pos + 3'(k);
                        cont = scan[idx[1:0]];
                        if (3'(k) < len) begin
                            if ((cont & u8u16_pkg::CONT_MASK) != u8u16_pkg::CONT_CODE) begin
                                ok = 1'b0;
                            end
                            cp = {cp[14:0], cont[5:0] & u8u16_pkg::PAYLOAD_MASK[5:0]};
                        end
                    end
                    if (!ok) begin
                        pos = pos + 3'd1;
                    end else begin
                        pos = pos + len;
                        if (cp <= u8u16_pkg::BMP_MAX) begin
                            if (n < 2'(MU)) begin
                                parse.units[n] = '{cp[15:0], 1'b1, 1'b0};
                                n = n + 2'd1;
                            end
                        end else begin
                            cp_off = cp - u8u16_pkg::SUPP_BASE;
                            if (n < 2'(MU)) begin
                                parse.units[n] = '{u8u16_pkg::HIGH_SURR
                                                   + 16'(cp_off[20:10]), 1'b1, 1'b0};
                                n = n + 2'd1;
                            end
                            if (n < 2'(MU)) begin
                                parse.units[n] = '{u8u16_pkg::LOW_SURR
                                                   + {6'd0, cp_off[9:0]}, 1'b1, 1'b0};
                                n = n + 2'd1;
                            end
                        end
                    end
                end
            end
        end

        // keep the unfinished tail, drop it at string end
        held_cnt_next = (stop && !in_last) ? 2'(total - pos) : 2'd0;
        for (int j = 0; j < HD; j++) begin
            idx = pos + 3'(j);
            held_bytes_next[j] = scan[idx[1:0]];
        end

        if (in_last) begin
            if (n == 2'd0) begin
                parse.units[0] = '{16'd0, 1'b0, 1'b1};
                n = 2'd1;
            end else begin
                parse.units[n - 2'd1].string_done = 1'b1;
            end
        end
        parse.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_cnt_reg <= 2'd0;
        end else if (advance) begin
            held_cnt_reg <= held_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            held_bytes_reg <= held_bytes_next;
        end
    end

    a_end_clears_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last) |=> (held_cnt_reg == 2'd0))
        else $error("held bytes survive the end of a string");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last) |-> (parse.count != 2'd0))
        else $error("final byte gave no result");

    a_bare_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && parse.count != 2'd0 && !parse.units[0].unit_valid) |-> in_last)
        else $error("bare result outside string end");

endmodule

>>> hdl/u8u16_result_buffer.sv
// ----------------------------------------------------------------------------
// u8u16_result_buffer
// Holds the code units of one decoded byte and presents them one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module u8u16_result_buffer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  u8u16_pkg::parse_t   parse,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [15:0]         m_code_unit,
    output logic                m_unit_valid,
    output logic                m_string_done
);

    localparam int MU = u8u16_pkg::MAX_UNITS;

    logic [1:0]                     cnt_reg;
    logic [1:0]                     cnt_next;
    u8u16_pkg::result_t [MU-1:0]    slot_reg;
    u8u16_pkg::result_t [MU-1:0]    slot_next;
    logic                           pop;

    assign pop      = m_valid && m_ready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (load) begin
            cnt_next  = parse.count;
            slot_next = parse.units;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            for (int i = 0; i < MU - 1; i++) begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign m_valid       = (cnt_reg != 2'd0);
    assign m_code_unit   = slot_reg[0].code_unit;
    assign m_unit_valid  = slot_reg[0].unit_valid;
    assign m_string_done = slot_reg[0].string_done;

    a_stall_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(cnt_reg))
        else $error("result count moved while stalled");

    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_unit_valid) |-> (m_string_done && m_code_unit == 16'd0))
        else $error("bare result without end mark");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("results overwritten before delivery");

endmodule

>>> hdl/utf8_to_utf16_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// UTF-8 byte stream in, UTF-16 code units out, end of string marked.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while s_ready is high. A byte that completes k code
// units (up to three, a surrogate pair counting as two) holds the input while
// the result buffer hands the units out one per cycle while m_ready is high; a
// byte that completes nothing does not hold the input. An accepted byte passes
// the input register, then the decoder into the result buffer, to its first unit.
// The final byte of a string always gives at least one result, carrying
// string_done; a string that ends without a unit gives a bare end result.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_unit_valid,
    output logic        m_string_done
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              can_load;
    logic              advance;
    u8u16_pkg::parse_t parse;

    assign advance = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_end_of_text;
        end
    end

    u8u16_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .parse   (parse)
    );

    u8u16_result_buffer u_result_buffer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance),
        .parse         (parse),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_unit_valid  (m_unit_valid),
        .m_string_done (m_string_done)
    );

endmodule
